### design/rau_pkg.sv
// Shared types and codes for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_N,
        S_MUL_D,
        S_MUL_B,
        S_SUM,
        S_GCD_GO,
        S_GCD_WAIT,
        S_DIVN_GO,
        S_DIVN_WAIT,
        S_DIVD_GO,
        S_DIVD_WAIT,
        S_FINISH
    } t_state;

    // start request / completion between the sequencer and its units
    typedef struct packed {
        logic start;
    } t_unit_req;

    typedef struct packed {
        logic done;
    } t_unit_rsp;

endpackage

### design/rau_gcd.sv
// Binary GCD of two unsigned magnitudes, one shift or subtract per cycle.
// Depends on rau_pkg for the request/response structs.
module rau_gcd #(
    parameter int MW = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rau_pkg::t_unit_req  i_req,
    input  logic [MW-1:0]       i_a,
    input  logic [MW-1:0]       i_b,
    output rau_pkg::t_unit_rsp  o_rsp,
    output logic [MW-1:0]       o_g
);
    localparam int KW = $clog2(MW + 1);

    logic          r_busy, n_busy;
    logic          r_shift, n_shift;
    logic          r_done, n_done;
    logic [MW-1:0] r_u, n_u;
    logic [MW-1:0] r_v, n_v;
    logic [KW-1:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_shift <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_shift <= n_shift;
            r_done  <= n_done;
        end
        r_u <= n_u;
        r_v <= n_v;
        r_k <= n_k;
    end

    always_comb begin
        n_busy  = r_busy;
        n_shift = r_shift;
        n_done  = 1'b0;
        n_u     = r_u;
        n_v     = r_v;
        n_k     = r_k;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_shift = 1'b0;
            n_u     = i_a;
            n_v     = i_b;
            n_k     = '0;
        end else if (r_busy && r_shift) begin
            // restore the common factors of two
            if (r_k == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_u = r_u << 1;
                n_k = r_k - 1'b1;
            end
        end else if (r_busy) begin
            if (r_u == '0 || r_v == '0) begin
                n_u     = r_u | r_v;
                n_shift = 1'b1;
            end else if (!r_u[0] && !r_v[0]) begin
                n_u = r_u >> 1;
                n_v = r_v >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_u[0]) begin
                n_u = r_u >> 1;
            end else if (!r_v[0]) begin
                n_v = r_v >> 1;
            end else if (r_u >= r_v) begin
                n_u = r_u - r_v;
            end else begin
                n_v = r_v - r_u;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_g        = r_u;

endmodule

### design/rau_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rau_pkg for the request/response structs.
module rau_div #(
    parameter int MW = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rau_pkg::t_unit_req  i_req,
    input  logic [MW-1:0]       i_num,
    input  logic [MW-1:0]       i_den,
    output rau_pkg::t_unit_rsp  o_rsp,
    output logic [MW-1:0]       o_quo
);
    localparam int CW = $clog2(MW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [MW-1:0] r_rem, n_rem;
    logic [MW-1:0] r_quo, n_quo;
    logic [MW-1:0] r_den, n_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [MW:0]   w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    // remainder stays below the divisor, so MW bits hold it
    assign w_trial = {r_rem, r_quo[MW-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
            n_cnt  = CW'(MW - 1);
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = MW'(w_trial - {1'b0, r_den});
                n_quo = {r_quo[MW-2:0], 1'b1};
            end else begin
                n_rem = w_trial[MW-1:0];
                n_quo = {r_quo[MW-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_quo      = r_quo;

endmodule

### design/rational_arithmetic_unit.sv
// Rational ALU: cross products on one shared multiplier, binary GCD, then
// two restoring divisions by the GCD (MW = 2*OPERAND_WIDTH). From input transfer
// to o_valid: the cross products (add/sub: a third product and a signed sum), the
// GCD, the divisions (skipped for 0/0), then the finish step. One item at a time:
// o_ready stays low until finish hands the result on; finish stalls while an
// earlier result waits.
// Synchronous active-low reset clears control.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_a_num,
    input  logic [31:0] i_a_den,
    input  logic [31:0] i_b_num,
    input  logic [31:0] i_b_den,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_res_num,
    output logic [62:0] o_res_den,
    output logic        o_div_zero
);
    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;

    rau_pkg::t_state r_state, n_state;

    logic [1:0]    r_op;
    logic [W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic          r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic          r_dz, n_dz;
    logic [MW-1:0] r_pn, n_pn, r_pd, n_pd, r_pb, n_pb, r_g, n_g;
    logic          r_pn_s, n_pn_s, r_pd_s, n_pd_s, r_pb_s, n_pb_s;
    logic          r_valid, n_valid;
    logic [63:0]   r_res_num, n_res_num;
    logic [62:0]   r_res_den, n_res_den;
    logic          r_res_dz, n_res_dz;

    logic [W-1:0]  w_an, w_ad, w_bn, w_bd;
    logic [W-1:0]  mul_x, mul_y;
    logic          mul_xs, mul_ys;
    logic [MW-1:0] mul_p;
    logic          mul_neg;
    logic [63:0]   w_mag;
    logic          w_neg;

    rau_pkg::t_unit_req gcd_req, div_req;
    rau_pkg::t_unit_rsp gcd_rsp, div_rsp;
    logic [MW-1:0]      gcd_g, div_q, div_num;

    // magnitudes of the sign-extended operands; -2^(W-1) fits unsigned
    assign w_an = i_a_num[W-1] ? W'(~i_a_num[W-1:0] + 1'b1) : i_a_num[W-1:0];
    assign w_ad = i_a_den[W-1] ? W'(~i_a_den[W-1:0] + 1'b1) : i_a_den[W-1:0];
    assign w_bn = i_b_num[W-1] ? W'(~i_b_num[W-1:0] + 1'b1) : i_b_num[W-1:0];
    assign w_bd = i_b_den[W-1] ? W'(~i_b_den[W-1:0] + 1'b1) : i_b_den[W-1:0];

    // shared multiplier operand select
    always_comb begin
        mul_x  = r_an;
        mul_xs = r_an_s;
        mul_y  = r_bd;
        mul_ys = r_bd_s;
        case (r_state)
            rau_pkg::S_MUL_N: begin
                if (r_op == rau_pkg::OP_MUL) begin
                    mul_y  = r_bn;
                    mul_ys = r_bn_s;
                end
            end
            rau_pkg::S_MUL_D: begin
                mul_x  = r_ad;
                mul_xs = r_ad_s;
                if (r_op == rau_pkg::OP_DIV) begin
                    mul_y  = (r_bn == '0) ? W'(1) : r_bn;
                    mul_ys = r_bn_s;
                end
            end
            rau_pkg::S_MUL_B: begin
                mul_x  = r_ad;
                mul_xs = r_ad_s;
                mul_y  = r_bn;
                mul_ys = r_bn_s;
            end
            default: ;
        endcase
    end

    assign mul_p   = MW'(mul_x) * MW'(mul_y);
    assign mul_neg = (mul_xs ^ mul_ys) && (mul_p != '0);

    assign w_neg = (r_pn_s != r_pd_s) && (r_pn != '0);
    assign w_mag = 64'(r_pn);

    assign gcd_req.start = (r_state == rau_pkg::S_GCD_GO);
    assign div_req.start = (r_state == rau_pkg::S_DIVN_GO) ||
                           (r_state == rau_pkg::S_DIVD_GO);
    assign div_num       = (r_state == rau_pkg::S_DIVN_GO) ? r_pn : r_pd;

    rau_gcd #(.MW(MW)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (gcd_req),
        .i_a     (r_pd),
        .i_b     (r_pn),
        .o_rsp   (gcd_rsp),
        .o_g     (gcd_g)
    );

    rau_div #(.MW(MW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (r_g),
        .o_rsp   (div_rsp),
        .o_quo   (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            r_op   <= i_operation;
            r_an   <= w_an;
            r_ad   <= w_ad;
            r_bn   <= w_bn;
            r_bd   <= w_bd;
            r_an_s <= i_a_num[W-1];
            r_ad_s <= i_a_den[W-1];
            r_bn_s <= i_b_num[W-1];
            r_bd_s <= i_b_den[W-1];
        end
        r_dz      <= n_dz;
        r_pn      <= n_pn;
        r_pn_s    <= n_pn_s;
        r_pd      <= n_pd;
        r_pd_s    <= n_pd_s;
        r_pb      <= n_pb;
        r_pb_s    <= n_pb_s;
        r_g       <= n_g;
        r_res_num <= n_res_num;
        r_res_den <= n_res_den;
        r_res_dz  <= n_res_dz;
    end

    always_comb begin
        n_state   = r_state;
        n_dz      = r_dz;
        n_pn      = r_pn;
        n_pn_s    = r_pn_s;
        n_pd      = r_pd;
        n_pd_s    = r_pd_s;
        n_pb      = r_pb;
        n_pb_s    = r_pb_s;
        n_g       = r_g;
        n_res_num = r_res_num;
        n_res_den = r_res_den;
        n_res_dz  = r_res_dz;
        n_valid   = r_valid && !i_ready;
        case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_valid) n_state = rau_pkg::S_MUL_N;
            end
            rau_pkg::S_MUL_N: begin
                n_pn    = mul_p;
                n_pn_s  = mul_neg;
                n_state = rau_pkg::S_MUL_D;
            end
            rau_pkg::S_MUL_D: begin
                n_pd    = mul_p;
                n_pd_s  = mul_neg;
                n_dz    = (r_op == rau_pkg::OP_DIV) && (r_bn == '0);
                n_state = (r_op == rau_pkg::OP_ADD || r_op == rau_pkg::OP_SUB) ?
                          rau_pkg::S_MUL_B : rau_pkg::S_GCD_GO;
            end
            rau_pkg::S_MUL_B: begin
                n_pb    = mul_p;
                n_pb_s  = mul_neg ^ ((r_op == rau_pkg::OP_SUB) && (mul_p != '0));
                n_state = rau_pkg::S_SUM;
            end
            rau_pkg::S_SUM: begin
                // sign-magnitude add of the two cross products
                if (r_pn_s == r_pb_s) begin
                    n_pn = r_pn + r_pb;
                end else if (r_pn >= r_pb) begin
                    n_pn = r_pn - r_pb;
                end else begin
                    n_pn   = r_pb - r_pn;
                    n_pn_s = r_pb_s;
                end
                n_state = rau_pkg::S_GCD_GO;
            end
            rau_pkg::S_GCD_GO: n_state = rau_pkg::S_GCD_WAIT;
            rau_pkg::S_GCD_WAIT: begin
                if (gcd_rsp.done) begin
                    n_g     = gcd_g;
                    n_state = (gcd_g == '0) ? rau_pkg::S_FINISH : rau_pkg::S_DIVN_GO;
                end
            end
            rau_pkg::S_DIVN_GO: n_state = rau_pkg::S_DIVN_WAIT;
            rau_pkg::S_DIVN_WAIT: begin
                if (div_rsp.done) begin
                    n_pn    = div_q;
                    n_state = rau_pkg::S_DIVD_GO;
                end
            end
            rau_pkg::S_DIVD_GO: n_state = rau_pkg::S_DIVD_WAIT;
            rau_pkg::S_DIVD_WAIT: begin
                if (div_rsp.done) begin
                    n_pd    = div_q;
                    n_state = rau_pkg::S_FINISH;
                end
            end
            rau_pkg::S_FINISH: begin
                // hand the result to the output register once it is free
                if (!r_valid || i_ready) begin
                    n_res_num = w_neg ? 64'(64'd0 - w_mag) : w_mag;
                    n_res_den = 63'(64'(r_pd));
                    n_res_dz  = r_dz;
                    n_valid   = 1'b1;
                    n_state   = rau_pkg::S_IDLE;
                end
            end
            default: n_state = rau_pkg::S_IDLE;
        endcase
    end

    assign o_ready    = (r_state == rau_pkg::S_IDLE);
    assign o_valid    = r_valid;
    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_div_zero = r_res_dz;

endmodule

### design/rau_checker.sv
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends only on the top-level ports.
module rau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_res_num,
    input logic [62:0] o_res_den,
    input logic        o_div_zero
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_num) && $stable(o_res_den)
            && $stable(o_div_zero))
        else $error("result changed while stalled");

    // one item at a time: busy right after an input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while busy");

    // a zero numerator is fully reduced
    a_zero_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res_num == 64'd0 |-> o_res_den == 63'd0 || o_res_den == 63'd1)
        else $error("zero numerator not reduced");

    // a zero denominator leaves a unit or zero numerator
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res_den == 63'd0 |->
            o_res_num == 64'd0 || o_res_num == 64'd1 || o_res_num == '1)
        else $error("zero denominator not reduced");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_res_num  (o_res_num),
    .o_res_den  (o_res_den),
    .o_div_zero (o_div_zero)
);

### verif/tb_rational_arithmetic_unit.sv
// Testbench for rational_arithmetic_unit: random and directed fraction operations,
// checked against an in-bench predictor of the reduced result.
// Depends on design/rau_pkg.sv and design/rational_arithmetic_unit.sv.
module tb_rational_arithmetic_unit;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] an, ad, bn, bd;
    } t_frac_op;

    typedef struct {
        logic [63:0] num;
        logic [62:0] den;
        logic        dz;
    } t_frac_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = '0;
    logic [31:0] i_a_num = '0, i_a_den = '0, i_b_num = '0, i_b_den = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_res_num;
    logic [62:0] o_res_den;
    logic        o_div_zero;

    rational_arithmetic_unit dut (.*);

    always #5 i_clk = ~i_clk;

    t_frac_op  pending_ops[$];
    t_frac_res expected_res[$];
    int        mismatches = 0;
    int        idle_phase = 0;   // 0: sender 17%, rcv 72%; 1: swapped; 2: none
    int        quiet_cycles = 0;
    localparam int QUIET_LIMIT = 20000;

    // valid and ready sampled at the last rising edge: tells the driver the transfer happened
    logic o_ready_q = 1'b0;
    always @(posedge i_clk) o_ready_q <= i_valid && o_ready;

    // multiply two sign-extended operands into sign/magnitude
    function automatic void smul(input logic signed [63:0] x, y,
                                 output bit neg, output logic [63:0] mag);
        logic signed [63:0] p;
        p   = x * y;
        neg = p < 0;
        mag = neg ? -p : p;
    endfunction

    function automatic void sadd(input bit xn, input logic [63:0] xm,
                                 input bit yn, input logic [63:0] ym,
                                 output bit rn, output logic [63:0] rm);
        if (xn == yn) begin
            rn = xn; rm = xm + ym;
        end else if (xm >= ym) begin
            rn = xn; rm = xm - ym;
        end else begin
            rn = yn; rm = ym - xm;
        end
        if (rm == 0) rn = 1'b0;
    endfunction

    function automatic t_frac_res reduce_fraction(t_frac_op t);
        logic signed [63:0] an, ad, bn, bd;
        bit n1, n2, nn, dn, neg;
        logic [63:0] m1, m2, nm, dm, g, a, b, tmp;
        t_frac_res r;
        an = $signed(t.an); ad = $signed(t.ad);
        bn = $signed(t.bn); bd = $signed(t.bd);
        r.dz = 1'b0;
        case (t.op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                smul(an, bd, n1, m1);
                smul(ad, bn, n2, m2);
                if (t.op == rau_pkg::OP_SUB) n2 = (m2 == 0) ? 1'b0 : ~n2;
                sadd(n1, m1, n2, m2, nn, nm);
                smul(ad, bd, dn, dm);
            end
            rau_pkg::OP_MUL: begin
                smul(an, bn, nn, nm);
                smul(ad, bd, dn, dm);
            end
            default: begin
                smul(an, bd, nn, nm);
                if (bn != 0) smul(ad, bn, dn, dm);
                else begin
                    r.dz = 1'b1;
                    smul(ad, 64'sd1, dn, dm);
                end
            end
        endcase
        a = dm; b = nm;
        while (b != 0) begin
            tmp = b; b = a % b; a = tmp;
        end
        g = a;
        if (g != 0) begin
            nm = nm / g; dm = dm / g;
        end
        neg = (nn != dn) && nm != 0;
        r.num = neg ? -nm : nm;
        r.den = dm[62:0];
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0001 + $urandom_range(0, 2) - 1; // near -2^31
            1: return 32'h7fff_ffff - $urandom_range(0, 1);
            2: return '0;
            3: return 32'd1;
            4, 5: return $urandom_range(0, 40) - 20;
            6: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || o_ready_q) begin
                if (pending_ops.size() > 0 &&
                    !(idle_phase == 0 && $urandom_range(0, 99) < 17) &&
                    !(idle_phase == 1 && $urandom_range(0, 99) < 72)) begin
                    i_valid     <= 1'b1;
                    i_operation <= pending_ops[0].op;
                    i_a_num     <= pending_ops[0].an;
                    i_a_den     <= pending_ops[0].ad;
                    i_b_num     <= pending_ops[0].bn;
                    i_b_den     <= pending_ops[0].bd;
                    expected_res.push_back(reduce_fraction(pending_ops[0]));
                    void'(pending_ops.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= !((idle_phase == 0 && $urandom_range(0, 99) < 72) ||
                         (idle_phase == 1 && $urandom_range(0, 99) < 17));
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (o_valid && i_ready) begin
                if (expected_res.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transfer");
                end else begin
                    if (o_res_num !== expected_res[0].num ||
                        o_res_den !== expected_res[0].den ||
                        o_div_zero !== expected_res[0].dz) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d dz %0b got %0d/%0d dz %0b",
                                     $signed(expected_res[0].num), expected_res[0].den,
                                     expected_res[0].dz, $signed(o_res_num), o_res_den,
                                     o_div_zero);
                    end
                    void'(expected_res.pop_front());
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic add_op(logic [1:0] op, logic [31:0] an, ad, bn, bd);
        t_frac_op t;
        t.op = op; t.an = an; t.ad = ad; t.bn = bn; t.bd = bd;
        pending_ops.push_back(t);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() > 0 || i_valid || expected_res.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [1:0] op;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, each operation, zero parts, divide by zero, 2^63
        for (int k = 0; k < 4; k++) begin
            op = 2'(k);
            add_op(op, 32'd1, 32'd2, 32'd1, 32'd3);
            add_op(op, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            add_op(op, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
            add_op(op, 32'd0, 32'd0, 32'd0, 32'd0);
            add_op(op, 32'd0, 32'd5, 32'd7, 32'd1);
        end
        add_op(rau_pkg::OP_DIV, 32'd6, 32'hffff_fffc, 32'd0, 32'd9);
        add_op(rau_pkg::OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        add_op(rau_pkg::OP_ADD, 32'd5, 32'd0, 32'd3, 32'd0);
        add_op(rau_pkg::OP_SUB, 32'hffff_fffb, 32'd0, 32'd2, 32'd1);
        add_op(rau_pkg::OP_SUB, 32'd3, 32'd4, 32'd3, 32'd4);
        for (int p = 0; p < 3; p++) begin
            idle_phase = p;
            for (int n = 0; n < 267; n++)
                add_op(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                       rand_operand(), rand_operand());
            wait_drained();
        end
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && expected_res.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
